FILE: sv/stable_givens_rotation_defines.svh
// Assertion macros for the Givens rotation block.
`ifndef STABLE_GIVENS_ROTATION_DEFINES_SVH
`define STABLE_GIVENS_ROTATION_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SGR_ASSERT_IMPLY(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("sgr check failed");

// Implication after a fixed number of cycles.
`define SGR_ASSERT_DELAY(label, a, n, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> ##n (b)) \
		else $error("sgr timing check failed");

`endif

FILE: sv/sgr_pkg.sv
// Shared constants for the Givens rotation block.
package sgr_pkg;
	localparam int FRAC_BITS   = 16;
	localparam int TRIG_W      = 18;
	localparam int MAG_W       = 16;
	// quotient of 2^(2F+2) * m^2 / s, at most 2^(2F+2)
	localparam int QUO_BITS    = 2 * FRAC_BITS + 3;
	localparam int ROOT_RW     = QUO_BITS + 1;
	localparam int TRIG_ROOT_W = ROOT_RW / 2;
	localparam int RATIO_LAT   = QUO_BITS + TRIG_ROOT_W + 1;
	localparam int TOP_LAT     = 3 + RATIO_LAT + 1;
	localparam logic signed [TRIG_W-1:0] ONE_Q   = 18'sd65536;
	localparam logic [MAG_W-1:0]         MAG_MAX = 16'hFFFF;
endpackage

FILE: sv/sgr_sqrt_pipe.sv
// Pipelined restoring square root, one root bit per stage.
module sgr_sqrt_pipe #(
	parameter int RW = 36,
	parameter int TW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [RW-1:0]    rad,
	input  logic [TW-1:0]    in_tag,
	output logic             out_vld,
	output logic [RW/2-1:0]  root,
	output logic [RW/2+1:0]  rem,
	output logic [TW-1:0]    out_tag
);
	localparam int K = RW / 2;

	logic          vld_s  [K];
	logic [RW-1:0] rad_s  [K-1];
	logic [K-1:0]  root_s [K];
	logic [K+1:0]  rem_s  [K];
	logic [TW-1:0] tag_s  [K];

	for (genvar k = 0; k < K; k++) begin : g_stage
		logic          vld_in;
		logic [RW-1:0] rad_in;
		logic [K-1:0]  root_in;
		logic [K+1:0]  rem_in;
		logic [TW-1:0] tag_in;
		logic [K+3:0]  t;
		logic [K+3:0]  trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rad_in  = rad;
			assign root_in = '0;
			assign rem_in  = '0;
			assign tag_in  = in_tag;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign root_in = root_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign tag_in  = tag_s[k-1];
		end

		assign t     = {rem_in, rad_in[RW-1-2*k -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = (t >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else
				vld_s[k] <= vld_in;
		end

		always_ff @(posedge clk) begin
			tag_s[k]  <= tag_in;
			root_s[k] <= {root_in[K-2:0], ge};
			rem_s[k]  <= ge ? (K+2)'(t - trial) : t[K+1:0];
		end

		if (k < K - 1) begin : g_rad
			always_ff @(posedge clk) begin
				rad_s[k] <= rad_in;
			end
		end
	end

	assign out_vld = vld_s[K-1];
	assign root    = root_s[K-1];
	assign rem     = rem_s[K-1];
	assign out_tag = tag_s[K-1];
endmodule

FILE: sv/sgr_div_pipe.sv
// Pipelined restoring divider: num * 2^(QUO_BITS-1) / den, for num <= den.
module sgr_div_pipe #(
	parameter int SW = 32,
	parameter int TW = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [SW-1:0]                 num,
	input  logic [SW-1:0]                 den,
	input  logic [TW-1:0]                 in_tag,
	output logic                          out_vld,
	output logic [sgr_pkg::QUO_BITS-1:0]  quo,
	output logic [TW-1:0]                 out_tag
);
	import sgr_pkg::*;

	logic                vld_s [QUO_BITS];
	logic [SW-1:0]       rem_s [QUO_BITS-1];
	logic [SW-1:0]       den_s [QUO_BITS-1];
	logic [QUO_BITS-1:0] quo_s [QUO_BITS];
	logic [TW-1:0]       tag_s [QUO_BITS];

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
		logic                vld_in;
		logic [SW:0]         r2;
		logic [SW-1:0]       dn;
		logic [QUO_BITS-1:0] quo_in;
		logic [TW-1:0]       tag_in;
		logic [SW:0]         diff;
		logic                ge;

		if (k == 0) begin : g_first
			assign vld_in = in_vld;
			assign r2     = {1'b0, num};
			assign dn     = den;
			assign quo_in = '0;
			assign tag_in = in_tag;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign r2     = {rem_s[k-1], 1'b0};
			assign dn     = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		assign diff = r2 - {1'b0, dn};
		assign ge   = (r2 >= {1'b0, dn});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else
				vld_s[k] <= vld_in;
		end

		always_ff @(posedge clk) begin
			quo_s[k] <= {quo_in[QUO_BITS-2:0], ge};
			tag_s[k] <= tag_in;
		end

		// remainder stays below den, so SW bits hold it
		if (k < QUO_BITS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? diff[SW-1:0] : r2[SW-1:0];
				den_s[k] <= dn;
			end
		end
	end

	assign out_vld = vld_s[QUO_BITS-1];
	assign quo     = quo_s[QUO_BITS-1];
	assign out_tag = tag_s[QUO_BITS-1];
endmodule

FILE: sv/sgr_ratio.sv
// Rounded Q2.16 ratio m / sqrt(s) as isqrt(floor(2^34 m^2 / s)), then halved with rounding.
module sgr_ratio #(
	parameter int SW = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  logic [SW-1:0]                      num,
	input  logic [SW-1:0]                      den,
	input  logic                               neg,
	output logic                               out_vld,
	output logic signed [sgr_pkg::TRIG_W-1:0]  trig
);
	import sgr_pkg::*;

	logic                   div_vld;
	logic [QUO_BITS-1:0]    div_quo;
	logic                   div_neg;
	logic                   sq_vld;
	logic [TRIG_ROOT_W-1:0] sq_root;
	logic                   sq_neg;
	logic [TRIG_ROOT_W:0]   f1;
	logic [TRIG_W-1:0]      q;
	logic                   vld_s1;
	logic signed [TRIG_W-1:0] trig_s1;

	sgr_div_pipe #(.SW(SW), .TW(1)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (in_vld),
		.num     (num),
		.den     (den),
		.in_tag  (neg),
		.out_vld (div_vld),
		.quo     (div_quo),
		.out_tag (div_neg)
	);

	sgr_sqrt_pipe #(.RW(ROOT_RW), .TW(1)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (div_vld),
		.rad     ({1'b0, div_quo}),
		.in_tag  (div_neg),
		.out_vld (sq_vld),
		.root    (sq_root),
		.rem     (),
		.out_tag (sq_neg)
	);

	// largest q with 2q-1 <= floor(root)
	assign f1 = {1'b0, sq_root} + (TRIG_ROOT_W+1)'(1);
	assign q  = TRIG_W'(f1[TRIG_ROOT_W:1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		trig_s1 <= sq_neg ? -$signed(q) : $signed(q);
	end

	assign out_vld = vld_s1;
	assign trig    = trig_s1;
endmodule

FILE: sv/stable_givens_rotation.sv
// The delay from an accepted request to the done strobe is the same for any INPUT_WIDTH.
// Throughput: one request per cycle; busy is always low, the pipeline never stalls.
// The depth is set by the 35-stage divider and 18-stage root of the cosine and sine paths.
// Reset (arst_n low) clears all valid bits; results in flight are dropped.
// Pipeline: abs, squares, sum, then divide / root / round per ratio and root for magnitude.
module stable_givens_rotation #(
	parameter int INPUT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [INPUT_WIDTH-1:0]      first_value,
	input  logic signed [INPUT_WIDTH-1:0]      second_value,
	output logic                               done,
	output logic signed [sgr_pkg::TRIG_W-1:0]  cosine,
	output logic signed [sgr_pkg::TRIG_W-1:0]  sine,
	output logic [sgr_pkg::MAG_W-1:0]          magnitude
);
	import sgr_pkg::*;

	localparam int W   = INPUT_WIDTH;
	localparam int SW  = 2 * W;
	localparam int DLY = RATIO_LAT - W;
	localparam int MW  = (W + 1 > MAG_W) ? W + 1 : MAG_W;

	logic          in_vld;
	logic [W-1:0]  abs_a;
	logic [W-1:0]  abs_b;

	logic          vld_s1, na_s1, nb_s1;
	logic [W-1:0]  ma_s1, mb_s1;
	logic          vld_s2, na_s2, nb_s2;
	logic [SW-1:0] a2_s2, b2_s2;
	logic          vld_s3, na_s3, nb_s3;
	logic [SW-1:0] a2_s3, b2_s3, s_s3;
	logic          zero_s3;

	logic                     ra_vld, rb_vld;
	logic signed [TRIG_W-1:0] ra_trig, rb_trig;

	logic          rho_vld, rho_zero;
	logic [W-1:0]  rho_root;
	logic [W+1:0]  rho_rem;
	logic [W:0]    rho_rnd;
	logic [MW-1:0] rho_ext;
	logic [MAG_W-1:0] rho_mag;

	logic             vld_dl_q  [DLY];
	logic             zero_dl_q [DLY];
	logic [MAG_W-1:0] mag_dl_q  [DLY];

	logic                     done_q;
	logic signed [TRIG_W-1:0] cos_q, sin_q;
	logic [MAG_W-1:0]         mag_q;

	assign busy   = 1'b0;
	assign in_vld = start & ~busy;
	assign abs_a  = first_value[W-1]  ? (~first_value  + W'(1)) : first_value;
	assign abs_b  = second_value[W-1] ? (~second_value + W'(1)) : second_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1 <= abs_a;
		mb_s1 <= abs_b;
		na_s1 <= first_value[W-1];
		nb_s1 <= second_value[W-1];
		a2_s2 <= SW'(ma_s1) * SW'(ma_s1);
		b2_s2 <= SW'(mb_s1) * SW'(mb_s1);
		na_s2 <= na_s1;
		nb_s2 <= nb_s1;
		a2_s3 <= a2_s2;
		b2_s3 <= b2_s2;
		s_s3  <= a2_s2 + b2_s2;
		na_s3 <= na_s2;
		nb_s3 <= nb_s2;
	end

	assign zero_s3 = (s_s3 == '0);

	sgr_ratio #(.SW(SW)) u_ratio_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.num     (a2_s3),
		.den     (s_s3),
		.neg     (na_s3),
		.out_vld (ra_vld),
		.trig    (ra_trig)
	);

	sgr_ratio #(.SW(SW)) u_ratio_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.num     (b2_s3),
		.den     (s_s3),
		.neg     (nb_s3),
		.out_vld (rb_vld),
		.trig    (rb_trig)
	);

	sgr_sqrt_pipe #(.RW(SW), .TW(1)) u_rho (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.rad     (s_s3),
		.in_tag  (zero_s3),
		.out_vld (rho_vld),
		.root    (rho_root),
		.rem     (rho_rem),
		.out_tag (rho_zero)
	);

	// round up when s - r^2 > r; saturate to the magnitude field
	assign rho_rnd = {1'b0, rho_root} + ((rho_rem > {2'b00, rho_root}) ? (W+1)'(1) : (W+1)'(0));
	assign rho_ext = MW'(rho_rnd);
	assign rho_mag = (rho_ext > MW'(MAG_MAX)) ? MAG_MAX : MAG_W'(rho_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DLY; i++)
				vld_dl_q[i] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_dl_q[0] <= rho_vld;
			for (int i = 1; i < DLY; i++)
				vld_dl_q[i] <= vld_dl_q[i-1];
			done_q <= ra_vld & rb_vld & vld_dl_q[DLY-1];
		end
	end

	always_ff @(posedge clk) begin
		zero_dl_q[0] <= rho_zero;
		mag_dl_q[0]  <= rho_mag;
		for (int i = 1; i < DLY; i++) begin
			zero_dl_q[i] <= zero_dl_q[i-1];
			mag_dl_q[i]  <= mag_dl_q[i-1];
		end
		cos_q <= zero_dl_q[DLY-1] ? ONE_Q : ra_trig;
		sin_q <= zero_dl_q[DLY-1] ? '0 : rb_trig;
		mag_q <= mag_dl_q[DLY-1];
	end

	assign done      = done_q;
	assign cosine    = cos_q;
	assign sine      = sin_q;
	assign magnitude = mag_q;
endmodule

FILE: sv/sgr_checker.sv
// Port-level checks for the Givens rotation block, bound to the top level.
`include "stable_givens_rotation_defines.svh"

module sgr_checker #(
	parameter int INPUT_WIDTH = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic signed [INPUT_WIDTH-1:0]      first_value,
	input logic signed [INPUT_WIDTH-1:0]      second_value,
	input logic                               done,
	input logic signed [sgr_pkg::TRIG_W-1:0]  cosine,
	input logic signed [sgr_pkg::TRIG_W-1:0]  sine,
	input logic [sgr_pkg::MAG_W-1:0]          magnitude
);
	import sgr_pkg::*;

	localparam int LAT = TOP_LAT;

	logic zero_req;
	logic zero_out;

	assign zero_req = start && !busy && first_value == '0 && second_value == '0;
	assign zero_out = cosine == ONE_Q && sine == '0 && magnitude == '0;

	`SGR_ASSERT_IMPLY(a_never_busy, 1'b1, !busy)
	`SGR_ASSERT_DELAY(a_done_follows, start && !busy, LAT, done)
	`SGR_ASSERT_DELAY(a_no_spurious_done, !(start && !busy), LAT, !done)
	`SGR_ASSERT_DELAY(a_zero_pair, zero_req, LAT, zero_out)
endmodule

bind stable_givens_rotation sgr_checker #(.INPUT_WIDTH(INPUT_WIDTH)) u_sgr_checker (.*);

FILE: verif/stable_givens_rotation_checker.sv
// Checker for the Givens rotation block: watches requests and results, predicts and compares.
`timescale 1ns / 100ps
module stable_givens_rotation_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic signed [15:0]                first_value,
	input  logic signed [15:0]                second_value,
	input  logic                              done,
	input  logic signed [sgr_pkg::TRIG_W-1:0] cosine,
	input  logic signed [sgr_pkg::TRIG_W-1:0] sine,
	input  logic [sgr_pkg::MAG_W-1:0]         magnitude,
	output int                                errors,
	output int                                pending,
	output int                                rotations_seen
);
	import sgr_pkg::*;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_q;
		logic signed [TRIG_W-1:0] sin_q;
		logic [MAG_W-1:0]         mag;
	} rotation_t;

	rotation_t expected_rotations[$];

	initial begin
		errors = 0;
		rotations_seen = 0;
	end

	assign pending = expected_rotations.size();

	// round(2^16 * m / sqrt(s)): largest q with (2q-1)^2 * s <= 2^34 * m^2
	function automatic logic [16:0] unit_ratio(input logic [15:0] m, input logic [31:0] s);
		logic [16:0]  lo;
		logic [16:0]  hi;
		logic [16:0]  mid;
		logic [127:0] lhs;
		logic [127:0] rhs;
		lo = 0;
		hi = 17'd65536;
		rhs = {96'd0, m} * m;
		rhs = rhs << 34;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			lhs = {111'd0, mid} * 2 - 1;
			lhs = lhs * lhs * s;
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic rotation_t rotate_pair(input logic signed [15:0] a,
			input logic signed [15:0] b);
		rotation_t   r;
		logic [15:0] ma;
		logic [15:0] mb;
		logic [31:0] s;
		logic [31:0] root;
		logic [16:0] qa;
		logic [16:0] qb;
		ma = a[15] ? -a : a;
		mb = b[15] ? -b : b;
		s = ma * ma + mb * mb;
		if (s == 0) begin
			r.cos_q = ONE_Q;
			r.sin_q = 0;
			r.mag = 0;
			return r;
		end
		root = 0;
		for (int k = 15; k >= 0; k--)
			if ((root | (32'd1 << k)) * (root | (32'd1 << k)) <= s)
				root |= 32'd1 << k;
		if (s - root * root > root)
			root += 1;
		if (root > MAG_MAX)
			root = MAG_MAX;
		qa = unit_ratio(ma, s);
		qb = unit_ratio(mb, s);
		r.cos_q = a[15] ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
		r.sin_q = b[15] ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
		r.mag = root[MAG_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %0d: %s got %0d expected %0d", rotations_seen, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		rotation_t want;
		if (arst_n) begin
			if (start && !busy)
				expected_rotations.push_back(rotate_pair(first_value, second_value));
			if (done) begin
				if (expected_rotations.size() == 0) begin
					$display("result with no request outstanding");
					errors++;
				end else begin
					want = expected_rotations.pop_front();
					if (cosine !== want.cos_q)
						report_mismatch("cosine", cosine, want.cos_q);
					if (sine !== want.sin_q)
						report_mismatch("sine", sine, want.sin_q);
					if (magnitude !== want.mag)
						report_mismatch("magnitude", magnitude, want.mag);
				end
				rotations_seen++;
			end
		end
	end
endmodule

FILE: verif/stable_givens_rotation_test.sv
// Top of the Givens rotation testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module stable_givens_rotation_test;
	import sgr_pkg::*;

	localparam int RANDOM_PAIRS = 1200;
	localparam int STALL_LIMIT  = 2000;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [15:0]        first_value;
	logic signed [15:0]        second_value;
	logic                      done;
	logic signed [TRIG_W-1:0]  cosine;
	logic signed [TRIG_W-1:0]  sine;
	logic [MAG_W-1:0]          magnitude;
	int                        errors;
	int                        pending;
	int                        rotations_seen;
	int                        quiet_cycles;
	int                        requests_sent;

	stable_givens_rotation #(.INPUT_WIDTH(16)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_value(first_value), .second_value(second_value),
		.done(done), .cosine(cosine), .sine(sine), .magnitude(magnitude)
	);

	stable_givens_rotation_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_value(first_value), .second_value(second_value),
		.done(done), .cosine(cosine), .sine(sine), .magnitude(magnitude),
		.errors(errors), .pending(pending), .rotations_seen(rotations_seen)
	);

	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// watchdog: cycles with neither a request nor a result accepted
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// hold one request until accepted, with an optional gap before it
	task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input bit may_idle);
		if (may_idle)
			while ($urandom_range(99) < 38) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start <= 1'b1;
		first_value <= a;
		second_value <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	function automatic logic [15:0] random_operand();
		case ($urandom_range(5))
			0: return 16'($urandom_range(7));
			1: return 16'(-$urandom_range(7));
			2: return 16'h8000 | 16'($urandom_range(3));
			3: return 16'h7FFF - 16'($urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] directed[12][2];
		quiet_cycles = 0;
		requests_sent = 0;
		arst_n = 0;
		start = 1'b0;
		first_value = 0;
		second_value = 0;
		directed = '{
			'{16'd0, 16'd0}, '{16'd5, 16'd0}, '{-16'd5, 16'd0}, '{16'd0, 16'd9},
			'{16'd0, -16'd9}, '{16'h7FFF, 16'h7FFF}, '{16'h8000, 16'h8000},
			'{16'h8000, 16'h7FFF}, '{16'h7FFF, 16'h8000}, '{16'd3, 16'd4},
			'{-16'd1, 16'd1}, '{16'hFFFF, 16'h5555}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i])
			send_pair(directed[i][0], directed[i][1], 0);
		start <= 1'b0;
		// let the pipeline drain completely once
		while (pending != 0)
			@(posedge clk);
		for (int n = 0; n < RANDOM_PAIRS; n++)
			send_pair(random_operand(), random_operand(), !(n >= 300 && n < 500));
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (TOP_LAT + 5) @(posedge clk);
		$display("%0d rotations requested, %0d checked: signs, zeros, full-scale extremes",
			requests_sent, rotations_seen);
		$display("and random pairs with idle gaps and a back-to-back stretch.");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

FILE: stable_givens_rotation.f
+incdir+sv
sv/sgr_pkg.sv
sv/sgr_sqrt_pipe.sv
sv/sgr_div_pipe.sv
sv/sgr_ratio.sv
sv/stable_givens_rotation.sv
sv/sgr_checker.sv
verif/stable_givens_rotation_checker.sv
verif/stable_givens_rotation_test.sv
